// ===== hdl/mft_pkg.sv =====
// Shared constants and types for the motor feedback turn tracker.
`default_nettype none
package mft_pkg;

	// Default configuration of the tracker
	localparam int NUM_SLOTS_DEF       = 4;
	localparam int COUNTS_PER_TURN_DEF = 8192;
	localparam int QUEUE_DEPTH_DEF     = 2;

	// Frame identifier width and stream widths
	localparam int ID_W     = 11;
	localparam int IN_W     = 64;
	localparam int OUT_W    = 200;
	localparam int OUT_USER_W = 3;

	// Register reset values
	localparam logic [ID_W-1:0] ID_BASE_RST       = 11'd513;
	localparam logic [31:0]     ANGLE_GAIN_RST    = 32'd38805;
	localparam logic [31:0]     VELOCITY_GAIN_RST = 32'd883011;

	// Register map: index is byte address divided by four
	localparam int ADDR_W = 4;
	typedef enum logic [1:0] {
		REG_ID_BASE       = 2'd0,
		REG_ANGLE_GAIN    = 2'd1,
		REG_VELOCITY_GAIN = 2'd2
	} reg_idx_t;

	// Half of one Q.24 to Q.16 step, used for round to nearest
	localparam int ROUND_HALF = 128;

endpackage
`default_nettype wire

// ===== hdl/mft_front.sv =====
// Front end: takes feedback frames, checks the identifier window and registers hits.
`default_nettype none
module mft_front #(
	parameter int NUM_SLOTS = mft_pkg::NUM_SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [mft_pkg::ID_W-1:0] id_base,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [mft_pkg::IN_W-1:0] s_tdata,
	output logic                     item_valid,
	input  logic                     item_ready,
	output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)+47:0] item_data
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int ITEM_W = SLOT_W + 48;

	logic [mft_pkg::ID_W:0]   offs;
	logic                     hit;
	logic [15:0]              pos;
	logic [15:0]              spd;
	logic [15:0]              amp;
	logic                     fr_valid_q;
	logic [ITEM_W-1:0]        fr_data_q;

	// Offset from the base without wrap; borrow marks a frame below the window
	assign offs = {1'b0, s_tdata[10:0]} - {1'b0, id_base};
	assign hit  = !offs[mft_pkg::ID_W] &&
	              (offs[mft_pkg::ID_W-1:0] < mft_pkg::ID_W'(NUM_SLOTS));

	// Assemble the big-endian payload words
	assign pos = {s_tdata[18:11], s_tdata[26:19]};
	assign spd = {s_tdata[34:27], s_tdata[42:35]};
	assign amp = {s_tdata[50:43], s_tdata[58:51]};

	assign s_tready   = !fr_valid_q || item_ready;
	assign item_valid = fr_valid_q;
	assign item_data  = fr_data_q;

	// Hold a frame in the window; drop any other frame at its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			fr_valid_q <= hit;
		end else if (item_ready) begin
			fr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			fr_data_q <= {amp, spd, pos, offs[SLOT_W-1:0]};
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mft_queue.sv =====
// Short first-in first-out queue between the front end and the tracking back end.
`default_nettype none
module mft_queue #(
	parameter int W     = 50,
	parameter int DEPTH = mft_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign in_ready  = (count_q != CW'(DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mft_back.sv =====
// Back end: per-slot turn unwrapping and the angle and speed scaling pipeline.
`default_nettype none
module mft_back #(
	parameter int NUM_SLOTS       = mft_pkg::NUM_SLOTS_DEF,
	parameter int COUNTS_PER_TURN = mft_pkg::COUNTS_PER_TURN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [31:0]                    angle_gain,
	input  logic [31:0]                    velocity_gain,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)+47:0] in_data,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mft_pkg::OUT_W-1:0]      m_tdata,
	output logic [mft_pkg::OUT_USER_W-1:0] m_tuser
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CPT_W  = $clog2(COUNTS_PER_TURN + 1);
	localparam int TOT_W  = CPT_W + 34;
	localparam int MH_W   = TOT_W - 32;
	localparam int HALF   = COUNTS_PER_TURN / 2;
	localparam logic signed [16:0]    HALF_S     = 17'(HALF);
	localparam logic signed [16:0]    NEG_HALF_S = -17'(HALF);
	localparam logic signed [CPT_W:0] CPT_S      = (CPT_W + 1)'(COUNTS_PER_TURN);
	localparam logic [56:0]           LIM_POS    = 57'h7FFF_FFFF_FFFF;
	localparam logic [56:0]           LIM_NEG    = 57'h8000_0000_0000;

	// Per-slot state
	logic        seen_q  [NUM_SLOTS];
	logic [31:0] turns_q [NUM_SLOTS];
	logic [15:0] last_q  [NUM_SLOTS];

	// Queue head fields
	logic [SLOT_W-1:0]  h_slot;
	logic [15:0]        h_pos;
	logic signed [15:0] h_spd;
	logic [15:0]        h_amp;
	logic               h_seen;
	logic signed [16:0] diff;
	logic [31:0]        turns_new;
	logic signed [31:0] vg_s;
	logic signed [47:0] spd_prod_c;
	logic               en;
	logic               pop;

	// Pipeline stages
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [SLOT_W-1:0]  slot_s1, slot_s2, slot_s3, slot_s4, slot_s5;
	logic               first_s1, first_s2, first_s3, first_s4, first_s5;
	logic [15:0]        pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;
	logic [31:0]        turns_s2, turns_s3, turns_s4, turns_s5;
	logic signed [31:0] turns_s1;
	logic [15:0]        amp_s1, amp_s2, amp_s3, amp_s4, amp_s5;
	logic signed [47:0] spd_prod_s1;
	logic               spd_neg_s2, spd_neg_s3;
	logic [47:0]        spd_mag_s2;
	logic [39:0]        spd_r_s3;
	logic [39:0]        speed_s4, speed_s5;
	logic signed [TOT_W-1:0] total_c;
	logic signed [TOT_W-1:0] total_s2;
	logic [47:0]        total48_s3, total48_s4, total48_s5;
	logic               t_neg_s3, t_neg_s4, t_neg_s5;
	logic [TOT_W-1:0]   t_mag_s3;
	logic [63:0]        plo_s4;
	logic [MH_W-1:0]    mh_s4;
	logic [MH_W+31:0]   phi_s5;
	logic [55:0]        plo_r_s5;
	logic [47:0]        spd_rnd_c;

	// Output stage
	logic               ovf;
	logic [56:0]        sum_c;
	logic [56:0]        lim_c;
	logic [47:0]        r_c;
	logic               out_valid_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               first_q;
	logic [15:0]        pos_q;
	logic [31:0]        turns_out_q;
	logic [47:0]        total_q;
	logic [47:0]        angle_q;
	logic [39:0]        speed_q;
	logic [15:0]        amp_q;

	// Whole pipeline moves when the output register is free or being taken
	assign en       = !out_valid_q || m_tready;
	assign in_ready = en;
	assign pop      = in_valid && en;

	assign h_slot = in_data[SLOT_W-1:0];
	assign h_pos  = in_data[SLOT_W +: 16];
	assign h_spd  = $signed(in_data[SLOT_W+16 +: 16]);
	assign h_amp  = in_data[SLOT_W+32 +: 16];
	assign vg_s   = $signed(velocity_gain);

	// Unwrap: a jump of more than half a turn is taken as a wrap
	assign h_seen = seen_q[h_slot];
	assign diff   = $signed({1'b0, h_pos}) - $signed({1'b0, last_q[h_slot]});

	always_comb begin
		if (!h_seen) begin
			turns_new = '0;
		end else if (diff > HALF_S) begin
			turns_new = turns_q[h_slot] - 32'd1;
		end else if (diff < NEG_HALF_S) begin
			turns_new = turns_q[h_slot] + 32'd1;
		end else begin
			turns_new = turns_q[h_slot];
		end
	end

	assign spd_prod_c = h_spd * vg_s;

	// Update slot state on each popped frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				seen_q[i]  <= 1'b0;
				turns_q[i] <= '0;
			end
		end else if (pop) begin
			seen_q[h_slot]  <= 1'b1;
			turns_q[h_slot] <= turns_new;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			last_q[h_slot] <= h_pos;
		end
	end

	// Multi-turn count, speed magnitude and rounding
	assign total_c   = turns_s1 * CPT_S + $signed({1'b0, pos_s1});
	assign spd_rnd_c = (spd_mag_s2 + 48'(mft_pkg::ROUND_HALF)) >> 8;

	// Angle: add the two partial products, then saturate
	assign ovf   = (phi_s5[MH_W+31:24] != '0);
	assign sum_c = {9'd0, phi_s5[23:0], 24'd0} + {1'b0, plo_r_s5};
	assign lim_c = t_neg_s5 ? LIM_NEG : LIM_POS;
	assign r_c   = (ovf || (sum_c > lim_c)) ? lim_c[47:0] : sum_c[47:0];

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	// Advance stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			slot_s1     <= h_slot;
			first_s1    <= !h_seen;
			pos_s1      <= h_pos;
			turns_s1    <= $signed(turns_new);
			amp_s1      <= h_amp;
			spd_prod_s1 <= spd_prod_c;

			slot_s2     <= slot_s1;
			first_s2    <= first_s1;
			pos_s2      <= pos_s1;
			turns_s2    <= turns_s1;
			amp_s2      <= amp_s1;
			total_s2    <= total_c;
			spd_neg_s2  <= spd_prod_s1[47];
			spd_mag_s2  <= spd_prod_s1[47] ? 48'(-spd_prod_s1) : 48'(spd_prod_s1);

			slot_s3     <= slot_s2;
			first_s3    <= first_s2;
			pos_s3      <= pos_s2;
			turns_s3    <= turns_s2;
			amp_s3      <= amp_s2;
			total48_s3  <= total_s2[47:0];
			t_neg_s3    <= total_s2[TOT_W-1];
			t_mag_s3    <= total_s2[TOT_W-1] ? TOT_W'(-total_s2) : TOT_W'(total_s2);
			spd_neg_s3  <= spd_neg_s2;
			spd_r_s3    <= spd_rnd_c[39:0];

			slot_s4     <= slot_s3;
			first_s4    <= first_s3;
			pos_s4      <= pos_s3;
			turns_s4    <= turns_s3;
			amp_s4      <= amp_s3;
			total48_s4  <= total48_s3;
			t_neg_s4    <= t_neg_s3;
			plo_s4      <= t_mag_s3[31:0] * angle_gain;
			mh_s4       <= t_mag_s3[TOT_W-1:32];
			speed_s4    <= spd_neg_s3 ? -spd_r_s3 : spd_r_s3;

			slot_s5     <= slot_s4;
			first_s5    <= first_s4;
			pos_s5      <= pos_s4;
			turns_s5    <= turns_s4;
			amp_s5      <= amp_s4;
			total48_s5  <= total48_s4;
			t_neg_s5    <= t_neg_s4;
			phi_s5      <= mh_s4 * angle_gain;
			plo_r_s5    <= 56'((plo_s4 + 64'(mft_pkg::ROUND_HALF)) >> 8);
			speed_s5    <= speed_s4;

			slot_q      <= slot_s5;
			first_q     <= first_s5;
			pos_q       <= pos_s5;
			turns_out_q <= turns_s5;
			total_q     <= total48_s5;
			angle_q     <= t_neg_s5 ? -r_c : r_c;
			speed_q     <= speed_s5;
			amp_q       <= amp_s5;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {amp_q, speed_q, angle_q, total_q, turns_out_q, pos_q};
	assign m_tuser  = {first_q, 2'(slot_q)};

endmodule
`default_nettype wire

// ===== hdl/motor_feedback_turn_tracker.sv =====
// Top level of the motor feedback turn tracker: register port, front end, queue, back end.
//
// Takes one motor feedback frame per transfer and, for frames whose identifier lies in
// [id_base, id_base + NUM_SLOTS - 1], gives one result transfer carrying the slot, the
// unwrapped multi-turn position, the angle in Q32.16 degrees (saturated), the speed in
// Q24.16 and the current; other frames are dropped with no result. The block sustains one
// frame per clock while m_tready is high, also for back-to-back frames to the same slot,
// because a slot's turn counter is read and written back in the cycle its frame is popped.
// From an input transfer to m_tvalid, the front register loads at the transfer itself,
// then the queue entry and the six registers of the back end follow, whose length is set
// by the two 32-bit partial products of the angle scaling. Slot state resets at once; no
// clearing pass is needed. Write the registers only while no frame is in flight.
`default_nettype none
module motor_feedback_turn_tracker #(
	parameter int NUM_SLOTS       = mft_pkg::NUM_SLOTS_DEF,
	parameter int COUNTS_PER_TURN = mft_pkg::COUNTS_PER_TURN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mft_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// Frames in
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata: frame_id[10:0], pos_hi[18:11], pos_lo[26:19], speed_hi[34:27],
	// speed_lo[42:35], amps_hi[50:43], amps_lo[58:51], zero[63:59]
	input  logic [mft_pkg::IN_W-1:0]       s_tdata,
	// Results out
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata: raw_position[15:0], turns[47:16], total_position[95:48],
	// angle_q16[143:96], speed_q16[183:144], motor_current[199:184]
	output logic [mft_pkg::OUT_W-1:0]      m_tdata,
	// m_tuser: motor_slot[1:0], first_frame[2]
	output logic [mft_pkg::OUT_USER_W-1:0] m_tuser
);

	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int ITEM_W = SLOT_W + 48;

	logic [mft_pkg::ID_W-1:0] id_base_q;
	logic [31:0]              angle_gain_q;
	logic [31:0]              velocity_gain_q;
	logic                     wr_en;
	mft_pkg::reg_idx_t        reg_idx;

	logic              fq_valid;
	logic              fq_ready;
	logic [ITEM_W-1:0] fq_data;
	logic              qb_valid;
	logic              qb_ready;
	logic [ITEM_W-1:0] qb_data;

	// Register port decode
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = mft_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q       <= mft_pkg::ID_BASE_RST;
			angle_gain_q    <= mft_pkg::ANGLE_GAIN_RST;
			velocity_gain_q <= mft_pkg::VELOCITY_GAIN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				mft_pkg::REG_ID_BASE:       id_base_q       <= pwdata[mft_pkg::ID_W-1:0];
				mft_pkg::REG_ANGLE_GAIN:    angle_gain_q    <= pwdata;
				mft_pkg::REG_VELOCITY_GAIN: velocity_gain_q <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			mft_pkg::REG_ID_BASE:       prdata = {21'd0, id_base_q};
			mft_pkg::REG_ANGLE_GAIN:    prdata = angle_gain_q;
			mft_pkg::REG_VELOCITY_GAIN: prdata = velocity_gain_q;
			default:                    prdata = '0;
		endcase
	end

	mft_front #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.id_base    (id_base_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.item_valid (fq_valid),
		.item_ready (fq_ready),
		.item_data  (fq_data)
	);

	mft_queue #(
		.W     (ITEM_W),
		.DEPTH (mft_pkg::QUEUE_DEPTH_DEF)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_data   (fq_data),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_data  (qb_data)
	);

	mft_back #(
		.NUM_SLOTS       (NUM_SLOTS),
		.COUNTS_PER_TURN (COUNTS_PER_TURN)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.angle_gain    (angle_gain_q),
		.velocity_gain (velocity_gain_q),
		.in_valid      (qb_valid),
		.in_ready      (qb_ready),
		.in_data       (qb_data),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser)
	);

	// A write to the identifier base lands in the register
	a_id_base_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && (paddr[3:2] == mft_pkg::REG_ID_BASE)) |=>
		(id_base_q == $past(pwdata[mft_pkg::ID_W-1:0])))
	else $error("id_base write not taken");

	// The first frame of a slot starts at turn zero
	a_first_turns: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tdata[47:16] == 32'd0))
	else $error("first frame with nonzero turn count");

	// With zero turns the multi-turn position equals the raw position
	a_first_total: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tdata[95:48] == {32'd0, m_tdata[15:0]}))
	else $error("first frame total position mismatch");

endmodule
`default_nettype wire
